// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on an explicit clock, held off while reset is low.
`define PCST_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on the block clock and reset.
`define PCST_ASSERT(lbl, prop, msg) `PCST_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/pcst_pkg.sv =====
package pcst_pkg;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int TMODE_W  = 3;
  localparam int COUNT_W  = 17;
  localparam int POS_W    = 11;
  localparam int STEP_W   = 32;
  localparam int PERIOD_W = 32;

  // Tone and loop constants
  localparam int LOOP_BUFFER_LENGTH = 1792;
  localparam int TIMER_CLOCK_HZ     = 1193182;
  localparam int SAMPLE_RATE_HZ     = 32000;
  localparam int MIN_TONE_COUNT     =
      (TIMER_CLOCK_HZ + (SAMPLE_RATE_HZ / 2) - 1) / (SAMPLE_RATE_HZ / 2);
  localparam int HALF_CLOCK_HZ      = TIMER_CLOCK_HZ / 2;

  // Divider and loop arithmetic widths
  localparam int CLOCK_W    = 21;                  // bits of the timer clock
  localparam int DVD_W      = CLOCK_W + STEP_W;    // clock << 32
  localparam int WHOLE_W    = 31;                  // loop span in timer ticks
  localparam int Q1_W       = 10;                  // whole periods in the span
  localparam int MUL_W      = Q1_W + PERIOD_W;
  localparam int LOOP_Q_W   = 12;                  // span over half clock
  localparam int DIV_CNT_W  = 6;
  localparam int SMP_PROD_W = STEP_W + POS_W;

  // Reciprocal of the half clock, exact for any span of WHOLE_W bits
  localparam int RECIP_SHIFT  = WHOLE_W + $clog2(HALF_CLOCK_HZ);
  localparam int RECIP_PROD_W = WHOLE_W + PERIOD_W;

  localparam logic [63:0] SPAN_FULL =
      64'(LOOP_BUFFER_LENGTH) * 64'(TIMER_CLOCK_HZ);
  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(HALF_CLOCK_HZ) - 64'd1) / 64'(HALF_CLOCK_HZ);
  localparam logic [WHOLE_W-1:0]  SPAN_VALUE  = SPAN_FULL[WHOLE_W-1:0];
  localparam logic [CLOCK_W-1:0]  CLOCK_VALUE = CLOCK_W'(TIMER_CLOCK_HZ);
  localparam logic [PERIOD_W-1:0] RATE_VALUE  = PERIOD_W'(SAMPLE_RATE_HZ);
  localparam logic [PERIOD_W-1:0] HALF_CLOCK_RECIP = RECIP_FULL[PERIOD_W-1:0];
  localparam logic [COUNT_W-1:0]  MIN_COUNT   = COUNT_W'(MIN_TONE_COUNT);
  localparam logic [POS_W-1:0]    LOOP_RESET  = POS_W'(LOOP_BUFFER_LENGTH);

  // Port bits and sample codes
  localparam int REFRESH_BIT = 4;
  localparam int TOUT_BIT    = 5;
  localparam logic [TMODE_W-1:0] TIMER_SQUARE_MODE = 3'd3;
  localparam logic [BYTE_W-1:0]  SAMPLE_LOW     = 8'd32;
  localparam logic [BYTE_W-1:0]  SAMPLE_HIGH    = 8'd224;
  localparam logic [BYTE_W-1:0]  SAMPLE_SILENCE = 8'd128;

  typedef enum logic [MODE_W-1:0] {
    MODE_PORT_WRITE = 2'd0,
    MODE_PORT_READ  = 2'd1,
    MODE_SAMPLE     = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIV_SPAN,
    DIV_PHASE
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SPAN_GO,
    ST_SPAN_WAIT,
    ST_MUL,
    ST_PHASE_GO,
    ST_PHASE_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic     latch_in;
    logic     load_count;
    logic     div_start;
    div_sel_e div_sel;
    logic     store_q1;
    logic     store_whole;
    logic     store_lq;
    logic     store_phase;
    logic     store_loop;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic recompute;
    logic eff_zero;
    logic div_busy;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== design/pcst_divider.sv =====
module pcst_divider import pcst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVD_W-1:0]     dividend_i,   // left aligned
  input  logic [PERIOD_W-1:0]  divisor_i,
  input  logic [DIV_CNT_W-1:0] nbits_i,
  output logic                 busy_o,
  output logic [STEP_W-1:0]    quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PERIOD_W-1:0]  rem_q, rem_d;
  logic [PERIOD_W-1:0]  dsr_q, dsr_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [STEP_W-1:0]    quot_q, quot_d;
  logic [PERIOD_W:0]    trial;
  logic [PERIOD_W:0]    diff;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    diff   = trial - {1'b0, dsr_q};
    fits   = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbits_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      quot_d = {quot_q[STEP_W-2:0], fits};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quot_q;

endmodule

// ===== design/pcst_datapath.sv =====
module pcst_datapath import pcst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_status_t       status_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [BYTE_W-1:0]  write_data_i,
  input  logic [TMODE_W-1:0] timer_mode_i,
  input  logic [COUNT_W-1:0] timer_count_i,
  input  logic               timer_gate_i,
  input  logic               timer_output_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [BYTE_W-1:0]  read_data_o,
  output logic               sample_valid_o,
  output logic [BYTE_W-1:0]  sample_o,
  output logic               gate_to_timer_o,
  output logic               speaker_enable_o
);

  // Held transaction
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [BYTE_W-1:0]  wdata_q, wdata_d;
  logic [TMODE_W-1:0] tmode_q, tmode_d;
  logic [COUNT_W-1:0] tcount_q, tcount_d;
  logic               tgate_q, tgate_d;
  logic               tout_q, tout_d;

  // Tone state
  logic [COUNT_W-1:0]  tone_q, tone_d;
  logic [POS_W-1:0]    loop_q, loop_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [STEP_W-1:0]   phase_q, phase_d;
  logic                de_q, de_d;
  logic                refresh_q, refresh_d;
  logic                gate_q, gate_d;

  // Loop build intermediates
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [Q1_W-1:0]     q1_q, q1_d;
  logic [WHOLE_W-1:0]  whole_q, whole_d;
  logic [LOOP_Q_W-1:0] lq_q, lq_d;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   rdata_q, rdata_d;
  logic                sv_q, sv_d;
  logic [BYTE_W-1:0]   smp_q, smp_d;
  logic                ogate_q, ogate_d;
  logic                ospk_q, ospk_d;

  logic [COUNT_W-1:0]   eff_count;
  logic                 square_req;
  logic [MUL_W-1:0]     whole_prod;
  logic [RECIP_PROD_W-1:0] loop_prod;
  logic [SMP_PROD_W-1:0] smp_prod;
  logic [POS_W:0]       pos_next;
  logic [LOOP_Q_W:0]    loop_round;
  logic [DVD_W-1:0]     div_dividend;
  logic [PERIOD_W-1:0]  div_divisor;
  logic [DIV_CNT_W-1:0] div_nbits;
  logic                 div_busy;
  logic [STEP_W-1:0]    div_quot;

  // Clamp short counts to silence and spot a count change
  assign eff_count  = (tcount_q < MIN_COUNT) ? '0 : tcount_q;
  assign square_req = (mode_q == MODE_SAMPLE) && (tmode_q == TIMER_SQUARE_MODE);

  assign status_o.recompute = square_req && (eff_count != tone_q);
  assign status_o.eff_zero  = (eff_count == '0);
  assign status_o.div_busy  = div_busy;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Route operands to the shared divider
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_SPAN: begin
        div_dividend = {SPAN_VALUE, (DVD_W - WHOLE_W)'(0)};
        div_divisor  = period_q;
        div_nbits    = DIV_CNT_W'(WHOLE_W);
      end
      DIV_PHASE: begin
        div_dividend = {CLOCK_VALUE, STEP_W'(0)};
        div_divisor  = period_q;
        div_nbits    = DIV_CNT_W'(DVD_W);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = period_q;
        div_nbits    = DIV_CNT_W'(WHOLE_W);
      end
    endcase
  end

  pcst_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .nbits_i    (div_nbits),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  assign whole_prod = MUL_W'(q1_q) * MUL_W'(period_q);
  // Divide the span by the half clock through its reciprocal
  assign loop_prod  = RECIP_PROD_W'(whole_q) * RECIP_PROD_W'(HALF_CLOCK_RECIP);
  assign smp_prod   = SMP_PROD_W'(phase_q) * SMP_PROD_W'(pos_q);
  assign pos_next   = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign loop_round = ({1'b0, lq_q} + (LOOP_Q_W + 1)'(1)) >> 1;

  always_comb begin
    mode_d      = mode_q;
    wdata_d     = wdata_q;
    tmode_d     = tmode_q;
    tcount_d    = tcount_q;
    tgate_d     = tgate_q;
    tout_d      = tout_q;
    tone_d      = tone_q;
    loop_d      = loop_q;
    pos_d       = pos_q;
    phase_d     = phase_q;
    de_d        = de_q;
    refresh_d   = refresh_q;
    gate_d      = gate_q;
    period_d    = period_q;
    q1_d        = q1_q;
    whole_d     = whole_q;
    lq_d        = lq_q;
    out_valid_d = out_valid_q;
    rdata_d     = rdata_q;
    sv_d        = sv_q;
    smp_d       = smp_q;
    ogate_d     = ogate_q;
    ospk_d      = ospk_q;

    // Capture the incoming transaction
    if (cmd_i.latch_in) begin
      mode_d   = mode_i;
      wdata_d  = write_data_i;
      tmode_d  = timer_mode_i;
      tcount_d = timer_count_i;
      tgate_d  = timer_gate_i;
      tout_d   = timer_output_i;
    end

    // Load a new count and restart the loop
    if (cmd_i.load_count) begin
      tone_d   = eff_count;
      pos_d    = '0;
      period_d = RATE_VALUE * PERIOD_W'(eff_count);
      if (eff_count == '0) begin
        phase_d = '0;
        loop_d  = LOOP_RESET;
      end
    end

    // Collect loop build results
    if (cmd_i.store_q1) begin
      q1_d = div_quot[Q1_W-1:0];
    end
    if (cmd_i.store_whole) begin
      whole_d = whole_prod[WHOLE_W-1:0];
    end
    if (cmd_i.store_lq) begin
      lq_d = loop_prod[RECIP_SHIFT +: LOOP_Q_W];
    end
    if (cmd_i.store_phase) begin
      phase_d = div_quot;
    end
    if (cmd_i.store_loop) begin
      loop_d = loop_round[POS_W-1:0];
    end

    // Retire a taken result
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Apply the transaction and fill the result register
    if (cmd_i.emit) begin
      rdata_d     = '0;
      sv_d        = 1'b0;
      smp_d       = '0;
      out_valid_d = 1'b1;
      unique case (mode_q)
        MODE_PORT_WRITE: begin
          de_d   = wdata_q[1];
          gate_d = wdata_q[0];
          if (wdata_q[0]) begin
            pos_d = '0;
          end
        end
        MODE_PORT_READ: begin
          refresh_d              = ~refresh_q;
          rdata_d[0]             = tgate_q;
          rdata_d[1]             = de_q;
          rdata_d[REFRESH_BIT]   = ~refresh_q;
          rdata_d[TOUT_BIT]      = tout_q;
        end
        MODE_SAMPLE: begin
          if (tmode_q == TIMER_SQUARE_MODE) begin
            sv_d = 1'b1;
            if (tone_q == '0) begin
              smp_d = SAMPLE_SILENCE;
            end else begin
              smp_d = smp_prod[31] ? SAMPLE_LOW : SAMPLE_HIGH;
            end
            if (pos_next >= {1'b0, loop_q}) begin
              pos_d = '0;
            end else begin
              pos_d = pos_next[POS_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
      ogate_d = gate_d;
      ospk_d  = gate_d & de_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_q      <= '0;
      loop_q      <= LOOP_RESET;
      pos_q       <= '0;
      phase_q     <= '0;
      de_q        <= 1'b0;
      refresh_q   <= 1'b0;
      gate_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tone_q      <= tone_d;
      loop_q      <= loop_d;
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      de_q        <= de_d;
      refresh_q   <= refresh_d;
      gate_q      <= gate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    wdata_q  <= wdata_d;
    tmode_q  <= tmode_d;
    tcount_q <= tcount_d;
    tgate_q  <= tgate_d;
    tout_q   <= tout_d;
    period_q <= period_d;
    q1_q     <= q1_d;
    whole_q  <= whole_d;
    lq_q     <= lq_d;
    rdata_q  <= rdata_d;
    sv_q     <= sv_d;
    smp_q    <= smp_d;
    ogate_q  <= ogate_d;
    ospk_q   <= ospk_d;
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rdata_q;
  assign sample_valid_o   = sv_q;
  assign sample_o         = smp_q;
  assign gate_to_timer_o  = ogate_q;
  assign speaker_enable_o = ospk_q;

endmodule

// ===== design/pcst_controller.sv =====
module pcst_controller import pcst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one transaction: decode, optional loop build, emit
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.recompute) begin
          cmd_o.load_count = 1'b1;
          state_d          = status_i.eff_zero ? ST_EMIT : ST_SPAN_GO;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SPAN_GO: begin
        cmd_o.div_sel   = DIV_SPAN;
        cmd_o.div_start = 1'b1;
        state_d         = ST_SPAN_WAIT;
      end
      ST_SPAN_WAIT: begin
        cmd_o.div_sel = DIV_SPAN;
        if (!status_i.div_busy) begin
          cmd_o.store_q1 = 1'b1;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.store_whole = 1'b1;
        state_d           = ST_PHASE_GO;
      end
      // Start the phase division and take the loop quotient alongside it
      ST_PHASE_GO: begin
        cmd_o.div_sel   = DIV_PHASE;
        cmd_o.div_start = 1'b1;
        cmd_o.store_lq  = 1'b1;
        state_d         = ST_PHASE_WAIT;
      end
      ST_PHASE_WAIT: begin
        cmd_o.div_sel = DIV_PHASE;
        if (!status_i.div_busy) begin
          cmd_o.store_phase = 1'b1;
          cmd_o.store_loop  = 1'b1;
          state_d           = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pc_speaker_tone_generator_unit.sv =====
// Path: an accepted transaction is decoded, then emitted into the result register;
// a sample with a new nonzero count first runs two bit-serial divisions of 31 and
// 53 bits on one divider. A new transaction is taken only when idle, after the
// last is emitted; the result register lets it enter while a result waits.
// Reset: asynchronous active low; silent 1792-sample loop, port bits cleared.
module pc_speaker_tone_generator_unit import pcst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [BYTE_W-1:0]  write_data_i,
  input  logic [TMODE_W-1:0] timer_mode_i,
  input  logic [COUNT_W-1:0] timer_count_i,
  input  logic               timer_gate_i,
  input  logic               timer_output_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  read_data_o,
  output logic               sample_valid_o,
  output logic [BYTE_W-1:0]  sample_o,
  output logic               gate_to_timer_o,
  output logic               speaker_enable_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  pcst_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcst_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .mode_i           (mode_i),
    .write_data_i     (write_data_i),
    .timer_mode_i     (timer_mode_i),
    .timer_count_i    (timer_count_i),
    .timer_gate_i     (timer_gate_i),
    .timer_output_i   (timer_output_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .read_data_o      (read_data_o),
    .sample_valid_o   (sample_valid_o),
    .sample_o         (sample_o),
    .gate_to_timer_o  (gate_to_timer_o),
    .speaker_enable_o (speaker_enable_o)
  );

endmodule

// ===== design/pcst_checker.sv =====
`include "assert_macros.svh"

module pcst_checker import pcst_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] read_data_o,
  input logic              sample_valid_o,
  input logic [BYTE_W-1:0] sample_o,
  input logic              gate_to_timer_o,
  input logic              speaker_enable_o
);

  logic res_held;
  logic code_ok;

  assign res_held = out_valid_o && out_stall_i;
  assign code_ok  = (sample_o == SAMPLE_LOW || sample_o == SAMPLE_HIGH ||
                     sample_o == SAMPLE_SILENCE) && read_data_o == '0;

  // Hold a stalled result
  `PCST_ASSERT(a_out_hold, res_held |=> out_valid_o, "result dropped while stalled")
  `PCST_ASSERT(a_out_stable, res_held |=> $stable(sample_o) && $stable(read_data_o), "result moved")

  // Sample results carry a tone or silence code and no port data
  `PCST_ASSERT(a_sample_code, out_valid_o && sample_valid_o |-> code_ok, "bad sample result")

  // Non-sample results carry a zero sample
  `PCST_ASSERT(a_no_sample, out_valid_o && !sample_valid_o |-> sample_o == '0, "sample without valid")

  // Speaker drive needs the gate
  `PCST_ASSERT(a_enable_gate, out_valid_o && speaker_enable_o |-> gate_to_timer_o, "speaker without gate")

endmodule

bind pc_speaker_tone_generator_unit pcst_checker u_pcst_checker (.*);
